### hdl/cpr_pkg.sv
// Package for the clock page replacement block: table sizes, widths and
// sequencer state codes. Depends on nothing; used by clock_page_replacement.
`default_nettype none

package cpr_pkg;

    // Built table depth and page number width.
    localparam int MAX_FRAMES = 128;
    localparam int PAGE_BITS  = 16;

    // Width of a frame index and of a count that can hold MAX_FRAMES itself.
    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);

    // Fixed field widths of the ports.
    localparam int CFG_W       = 8;
    localparam int OUT_FRAME_W = 7;
    localparam int TOTAL_W     = 32;
    localparam int EXT_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Frame count after reset.
    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = CFG_W'(128);

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RD    = 9'b000000010,
        ST_CMP   = 9'b000000100,
        ST_MISS  = 9'b000001000,
        ST_FILL  = 9'b000010000,
        ST_SWEEP = 9'b000100000,
        ST_EVRD  = 9'b001000000,
        ST_EVWR  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

### hdl/clock_page_replacement.sv
// Clock page replacement block: frame table memory, reference bits, clock hand
// and a small sequencer around one shared compare unit. Depends on cpr_pkg.
`default_nettype none

// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_page
// result    out        o_out_valid / i_out_ready    o_fault, o_frame, o_evicted_valid,
//                                                   o_evicted_page, o_fault_total
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_frame_count
//
// One request at a time: an accept step, a read and a compare per resident frame
// looked at, then on a miss a step to count it and fix the hand, and a step to
// load a free frame or, with a full table, sweep steps that clear reference bits
// (at most frame_count of them) plus steps to find, read and replace the victim.
// A final state passes the result to the output register; page zero skips to it.
// Reset is synchronous with no clearing pass; the fill count marks valid frames.
// A result waiting at the output stalls only the final cycle of the next request.
module clock_page_replacement (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [cpr_pkg::PAGE_BITS-1:0] i_page,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_fault,
    output logic [cpr_pkg::OUT_FRAME_W-1:0]    o_frame,
    output logic                               o_evicted_valid,
    output logic [cpr_pkg::PAGE_BITS-1:0]      o_evicted_page,
    output logic [cpr_pkg::TOTAL_W-1:0]        o_fault_total,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [cpr_pkg::CFG_W-1:0]     i_cfg_frame_count
);
    import cpr_pkg::*;

    // Frame table memory and its registered read data.
    logic [PAGE_BITS-1:0] r_mem [MAX_FRAMES];
    logic [PAGE_BITS-1:0] r_rd_data;

    // Control and bookkeeping registers.
    t_state               r_state;
    t_state               n_state;
    logic [CFG_W-1:0]     r_frame_count;
    logic [MAX_FRAMES-1:0] r_ref_bits;
    logic [FRAME_W-1:0]   r_hand;
    logic [CNT_W-1:0]     r_filled;
    logic [TOTAL_W-1:0]   r_fault_cnt;
    logic [FRAME_W-1:0]   r_idx;
    logic [PAGE_BITS-1:0] r_page;

    // Result staging and output registers.
    logic                 r_res_fault;
    logic [FRAME_W-1:0]   r_res_frame;
    logic                 r_res_ev_valid;
    logic [PAGE_BITS-1:0] r_res_ev_page;
    logic                 r_out_valid;
    logic                 r_out_fault;
    logic [OUT_FRAME_W-1:0] r_out_frame;
    logic                 r_out_ev_valid;
    logic [PAGE_BITS-1:0] r_out_ev_page;
    logic [TOTAL_W-1:0]   r_out_total;

    // Combinational helpers.
    logic [EXT_W-1:0]     w_cfg_ext;
    logic [CNT_W-1:0]     w_frames;
    logic [CNT_W-1:0]     w_limit;
    logic [CNT_W-1:0]     w_idx_inc;
    logic [CNT_W-1:0]     w_hand_inc;
    logic [FRAME_W-1:0]   n_hand_adv;
    logic                 w_in_acc;
    logic                 w_cfg_acc;
    logic                 w_out_free;
    logic                 w_mem_we;
    logic [FRAME_W-1:0]   w_rd_addr;

    // Frames in use: zero acts as one, anything above the table depth as the depth.
    always_comb begin
        w_cfg_ext = EXT_W'(r_frame_count);
        if (w_cfg_ext == '0) begin
            w_frames = CNT_W'(1);
        end else if (w_cfg_ext > EXT_W'(MAX_FRAMES)) begin
            w_frames = CNT_W'(MAX_FRAMES);
        end else begin
            w_frames = CNT_W'(w_cfg_ext);
        end
    end

    // Number of frames that take part in the lookup, and index and hand steps.
    assign w_limit    = (r_filled < w_frames) ? r_filled : w_frames;
    assign w_idx_inc  = CNT_W'(r_idx) + CNT_W'(1);
    assign w_hand_inc = CNT_W'(r_hand) + CNT_W'(1);
    assign n_hand_adv = (w_hand_inc >= w_frames) ? '0 : FRAME_W'(w_hand_inc);

    // Handshakes.
    assign o_in_ready  = (r_state == ST_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Memory port control: writes always land under the hand.
    assign w_mem_we  = (r_state == ST_FILL) || (r_state == ST_EVWR);
    assign w_rd_addr = (r_state == ST_EVRD) ? r_hand : r_idx;

    // Frame table memory.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_hand] <= r_page;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_page == '0) begin
                        n_state = ST_DONE;
                    end else if (w_limit == '0) begin
                        n_state = ST_MISS;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_rd_data == r_page) begin
                    n_state = ST_DONE;
                end else if (w_idx_inc < w_limit) begin
                    n_state = ST_RD;
                end else begin
                    n_state = ST_MISS;
                end
            end
            ST_MISS: begin
                n_state = (r_filled >= w_frames) ? ST_SWEEP : ST_FILL;
            end
            ST_FILL: begin
                n_state = ST_DONE;
            end
            ST_SWEEP: begin
                if (!r_ref_bits[r_hand]) begin
                    n_state = ST_EVRD;
                end
            end
            ST_EVRD: begin
                n_state = ST_EVWR;
            end
            ST_EVWR: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, table bookkeeping and result staging.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_frame_count <= FRAME_COUNT_RST;
            r_ref_bits    <= '0;
            r_hand        <= '0;
            r_filled      <= '0;
            r_fault_cnt   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            // The result register fills from the final state and empties when taken.
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    // A frame count write empties the table.
                    if (w_cfg_acc) begin
                        r_frame_count <= i_cfg_frame_count;
                        r_ref_bits    <= '0;
                        r_hand        <= '0;
                        r_filled      <= '0;
                    end
                    if (w_in_acc) begin
                        r_page         <= i_page;
                        r_idx          <= '0;
                        r_res_fault    <= 1'b0;
                        r_res_frame    <= '0;
                        r_res_ev_valid <= 1'b0;
                        r_res_ev_page  <= '0;
                    end
                end
                ST_CMP: begin
                    // A hit sets the frame's reference bit.
                    if (r_rd_data == r_page) begin
                        r_ref_bits[r_idx] <= 1'b1;
                        r_res_frame       <= r_idx;
                    end else begin
                        r_idx <= FRAME_W'(w_idx_inc);
                    end
                end
                ST_MISS: begin
                    // Count the fault and keep the hand inside the frames in use.
                    if (r_fault_cnt != '1) begin
                        r_fault_cnt <= r_fault_cnt + TOTAL_W'(1);
                    end
                    if (CNT_W'(r_hand) >= w_frames) begin
                        r_hand <= '0;
                    end
                    r_res_fault <= 1'b1;
                end
                ST_FILL: begin
                    // Load into the next free frame.
                    r_ref_bits[r_hand] <= 1'b1;
                    r_res_frame        <= r_hand;
                    r_hand             <= n_hand_adv;
                    r_filled           <= r_filled + CNT_W'(1);
                end
                ST_SWEEP: begin
                    // Give a referenced frame its second chance.
                    if (r_ref_bits[r_hand]) begin
                        r_ref_bits[r_hand] <= 1'b0;
                        r_hand             <= n_hand_adv;
                    end
                end
                ST_EVWR: begin
                    // Replace the victim under the hand.
                    r_ref_bits[r_hand] <= 1'b1;
                    r_res_frame        <= r_hand;
                    r_res_ev_valid     <= 1'b1;
                    r_res_ev_page      <= r_rd_data;
                    r_hand             <= n_hand_adv;
                end
                default: begin
                end
            endcase
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && w_out_free) begin
            r_out_fault    <= r_res_fault;
            r_out_frame    <= OUT_FRAME_W'(r_res_frame);
            r_out_ev_valid <= r_res_ev_valid;
            r_out_ev_page  <= r_res_ev_page;
            r_out_total    <= r_fault_cnt;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_fault         = r_out_fault;
    assign o_frame         = r_out_frame;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_out_total;

endmodule

`default_nettype wire
